>>> rtl/core/mmh_pkg.sv
package mmh_pkg;
  localparam int CAPACITY = 1024;
  localparam int KEY_WIDTH = 32;
  localparam int ADDR_W = $clog2(CAPACITY + 1);
  localparam int CNT_W = 11;

  typedef logic [KEY_WIDTH-1:0] key_t;
  typedef logic [ADDR_W-1:0] addr_t;
  typedef logic [CNT_W-1:0] cnt_t;

  localparam logic [2:0] CMD_INSERT   = 3'd0;
  localparam logic [2:0] CMD_POP_MIN  = 3'd1;
  localparam logic [2:0] CMD_POP_MAX  = 3'd2;
  localparam logic [2:0] CMD_EXCHANGE = 3'd3;
  localparam logic [2:0] CMD_PEEK_MIN = 3'd4;
  localparam logic [2:0] CMD_PEEK_MAX = 3'd5;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  function automatic logic key_less(input key_t a, input key_t b, input logic sgn);
    key_t ra;
    key_t rb;
    ra = a ^ {sgn, {(KEY_WIDTH-1){1'b0}}};
    rb = b ^ {sgn, {(KEY_WIDTH-1){1'b0}}};
    return ra < rb;
  endfunction
endpackage

>>> rtl/core/mmh_if.sv
interface mmh_req_if;
  logic valid;
  logic ready;
  logic [2:0] command;
  logic [31:0] key_in;
  modport source(output valid, command, key_in, input ready);
  modport sink(input valid, command, key_in, output ready);
endinterface

interface mmh_rsp_if;
  logic valid;
  logic ready;
  logic [31:0] key_out;
  logic [1:0] status;
  logic [10:0] element_count;
  modport source(output valid, key_out, status, element_count, input ready);
  modport sink(input valid, key_out, status, element_count, output ready);
endinterface

>>> rtl/core/min_max_heap.sv
// Peeks, inserts and pops all share one RAM read port, so their reads are made
// one after another.
// Throughput: one request at a time; ready again once the response is taken.
// Reset: synchronous rst empties the heap and clears sgn (signed-key mode);
// RAM contents are not cleared and need no clearing pass.
module min_max_heap (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_wdata,
  mmh_req_if.sink     req,
  mmh_rsp_if.source   rsp
);
  import mmh_pkg::*;

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_WT   = 4'd2;
  localparam logic [3:0] S_DISP = 4'd3;
  localparam logic [3:0] S_UPC  = 4'd4;
  localparam logic [3:0] S_RISE = 4'd5;
  localparam logic [3:0] S_TDC  = 4'd6;
  localparam logic [3:0] S_TDE  = 4'd7;
  localparam logic [3:0] S_TDP  = 4'd8;
  localparam logic [3:0] S_RESP = 4'd9;

  localparam logic [2:0] P_PEEK  = 3'd0;
  localparam logic [2:0] P_PAR   = 3'd1;
  localparam logic [2:0] P_GP    = 3'd2;
  localparam logic [2:0] P_LAST  = 3'd3;
  localparam logic [2:0] P_CAND  = 3'd4;
  localparam logic [2:0] P_MID   = 3'd5;
  localparam logic [2:0] P_S2    = 3'd6;
  localparam logic [2:0] P_S3    = 3'd7;

  logic [3:0] state;
  logic [2:0] purpose;
  logic [2:0] cmd;
  logic       sgn;
  cnt_t       cnt;
  addr_t      cur;
  addr_t      best;
  key_t       x;
  key_t       bestk;
  key_t       k2;
  key_t       res;
  logic [1:0] st;
  logic       want_max;
  logic [2:0] ci;
  logic       outv;

  logic       we;
  addr_t      waddr;
  key_t       wdata;
  addr_t      raddr;
  key_t       rdata;

  mmh_ram #(.WIDTH(KEY_WIDTH), .DEPTH(2 ** ADDR_W)) u_ram (
    .clk(clk), .we(we), .waddr(waddr), .wdata(wdata), .raddr(raddr), .rdata(rdata)
  );

  addr_t ra_reg;
  assign raddr = ra_reg;

  logic cur_min_lvl;
  always_comb begin
    cur_min_lvl = 1'b1;
    for (int b = 0; b < ADDR_W; b++) begin
      if (cur[b]) cur_min_lvl = (b % 2) == 0;
    end
  end

  function automatic logic better(input key_t a, input key_t b, input logic mx,
                                  input logic s);
    return mx ? key_less(b, a, s) : key_less(a, b, s);
  endfunction

  key_t cmp_a;
  key_t cmp_b;
  logic cmp_max;
  logic cmp_res;
  always_comb begin
    cmp_a = rdata;
    cmp_b = x;
    cmp_max = want_max;
    if (state == S_TDE) begin
      cmp_a = bestk;
    end else begin
      unique case (purpose)
        P_PAR: begin
          cmp_a = x; cmp_b = rdata; cmp_max = cur_min_lvl;
        end
        P_GP: begin
          cmp_a = x; cmp_b = rdata;
        end
        P_CAND: begin
          cmp_b = bestk;
        end
        P_S3: begin
          cmp_b = k2; cmp_max = 1'b1;
        end
        default: ;
      endcase
    end
  end
  assign cmp_res = better(cmp_a, cmp_b, cmp_max, sgn);

  logic [ADDR_W+1:0] cand_w;
  always_comb begin
    unique case (ci)
      3'd0: cand_w = {1'b0, cur, 1'b0};
      3'd1: cand_w = {1'b0, cur, 1'b1};
      3'd2: cand_w = {cur, 2'b00};
      3'd3: cand_w = {cur, 2'b01};
      3'd4: cand_w = {cur, 2'b10};
      default: cand_w = {cur, 2'b11};
    endcase
  end
  logic cand_ok;
  assign cand_ok = cand_w <= (ADDR_W + 2)'(cnt);

  assign req.ready = state == S_IDLE && !outv;
  assign rsp.valid = outv;
  assign rsp.key_out = res;
  assign rsp.status = st;
  assign rsp.element_count = cnt;

  always_ff @(posedge clk) begin
    we <= 1'b0;
    if (rst) begin
      state <= S_IDLE;
      cnt <= '0;
      sgn <= 1'b0;
      outv <= 1'b0;
    end else begin
      if (cfg_we) sgn <= cfg_wdata;
      if (outv && rsp.ready) outv <= 1'b0;
      unique case (state)
        S_IDLE: if (req.valid && req.ready) begin
          cmd <= req.command;
          x <= req.key_in;
          res <= '0;
          st <= ST_OK;
          state <= S_RESP;
          if (req.command == CMD_INSERT) begin
            if (cnt >= cnt_t'(CAPACITY)) st <= ST_FULL;
            else begin
              cnt <= cnt + 1'b1;
              cur <= addr_t'(cnt + 1'b1);
              if (cnt == '0) begin
                we <= 1'b1; waddr <= addr_t'(1); wdata <= req.key_in;
              end else begin
                ra_reg <= addr_t'((cnt + 1'b1) >> 1);
                purpose <= P_PAR; state <= S_WT;
              end
            end
          end else if (req.command >= CMD_POP_MIN && req.command <= CMD_PEEK_MAX) begin
            if (cnt == '0) st <= ST_EMPTY;
            else begin
              ra_reg <= addr_t'(1);
              purpose <= P_PEEK; state <= S_WT;
              if ((req.command == CMD_POP_MAX || req.command == CMD_PEEK_MAX)
                  && cnt > 11'd2) begin
                ra_reg <= addr_t'(2); purpose <= P_S2;
              end else if (req.command == CMD_POP_MAX || req.command == CMD_PEEK_MAX) begin
                ra_reg <= addr_t'(cnt);
              end
            end
          end
        end
        S_WT: state <= S_DISP;
        S_DISP: begin
          unique case (purpose)
            P_PEEK: begin
              res <= rdata;
              if (cmd == CMD_PEEK_MIN || cmd == CMD_PEEK_MAX) state <= S_RESP;
              else if (cmd == CMD_POP_MAX) begin
                cnt <= cnt - 1'b1; state <= S_RESP;
              end else if (cmd == CMD_EXCHANGE) begin
                cur <= addr_t'(1); want_max <= 1'b0; state <= S_TDC; ci <= '0;
                best <= '0;
              end else begin
                ra_reg <= addr_t'(cnt); purpose <= P_LAST; state <= S_WT;
                cur <= addr_t'(1); want_max <= 1'b0;
              end
            end
            P_S2: begin
              k2 <= rdata; ra_reg <= addr_t'(3); purpose <= P_S3; state <= S_WT;
            end
            P_S3: begin
              if (cmp_res) begin
                res <= rdata; cur <= addr_t'(3);
              end else begin
                res <= k2; cur <= addr_t'(2);
              end
              if (cmd == CMD_PEEK_MAX) state <= S_RESP;
              else begin
                ra_reg <= addr_t'(cnt); purpose <= P_LAST; state <= S_WT;
                want_max <= 1'b1;
              end
            end
            P_LAST: begin
              x <= rdata; cnt <= cnt - 1'b1;
              ci <= '0; best <= '0; state <= S_TDC;
            end
            P_PAR: begin
              if (cmp_res) begin
                we <= 1'b1; waddr <= cur; wdata <= rdata;
                cur <= cur >> 1; want_max <= cur_min_lvl;
              end else want_max <= !cur_min_lvl;
              state <= S_RISE;
            end
            P_GP: begin
              if (cmp_res) begin
                we <= 1'b1; waddr <= cur; wdata <= rdata;
                cur <= cur >> 2; state <= S_RISE;
              end else begin
                we <= 1'b1; waddr <= cur; wdata <= x; state <= S_RESP;
              end
            end
            P_CAND: begin
              if (best == '0 || cmp_res) begin
                best <= addr_t'(cand_w); bestk <= rdata;
              end
              ci <= ci + 1'b1; state <= S_TDC;
            end
            default: begin
              if (cmp_res) begin
                we <= 1'b1; waddr <= addr_t'(best >> 1); wdata <= x;
                x <= rdata;
              end
              cur <= best; ci <= '0; best <= '0; state <= S_TDC;
            end
          endcase
        end
        S_RISE: begin
          if ((cur >> 2) == '0) begin
            we <= 1'b1; waddr <= cur; wdata <= x; state <= S_RESP;
          end else begin
            ra_reg <= cur >> 2; purpose <= P_GP; state <= S_WT;
          end
        end
        S_TDC: begin
          if (ci == 3'd6 || !cand_ok) state <= S_TDE;
          else begin
            ra_reg <= addr_t'(cand_w); purpose <= P_CAND; state <= S_WT;
          end
        end
        S_TDE: begin
          if (best != '0 && cmp_res) begin
            we <= 1'b1; waddr <= cur; wdata <= bestk;
            if (best > addr_t'({cur, 1'b1})) begin
              ra_reg <= best >> 1; purpose <= P_MID; state <= S_WT;
            end else begin
              cur <= best; state <= S_TDP;
            end
          end else state <= S_TDP;
        end
        S_TDP: begin
          we <= 1'b1; waddr <= cur; wdata <= x; state <= S_RESP;
        end
        S_RESP: if (!outv) begin
          outv <= 1'b1; state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

>>> rtl/core/mmh_ram.sv
module mmh_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

>>> rtl/core/min_max_heap_chk.sv
module min_max_heap_chk (
  input logic        clk,
  input logic        rst,
  input logic        req_valid,
  input logic        req_ready,
  input logic        rsp_valid,
  input logic        rsp_ready,
  input logic [1:0]  status,
  input logic [10:0] element_count,
  input logic [31:0] key_out
);
  import mmh_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(key_out))
    else $error("response dropped");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("ready while busy");
  a_cnt: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> element_count <= cnt_t'(CAPACITY))
    else $error("count overflow");
  a_full: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == ST_FULL |-> element_count == cnt_t'(CAPACITY))
    else $error("full refusal below capacity");
endmodule

bind min_max_heap min_max_heap_chk u_chk (
  .clk(clk), .rst(rst), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
  .status(rsp.status), .element_count(rsp.element_count), .key_out(rsp.key_out)
);
